/* rtl/core/msm_pkg.sv */
// ----------------------------------------------------------------------------
// msm_pkg
// shared widths, register indexes and reset values of the max-sum submatrix
// search block
// ----------------------------------------------------------------------------
package msm_pkg;

   localparam int BEST_SUM_BITS  = 24;
   localparam int INDEX_BITS     = 4;
   localparam int CSR_DATA_BITS  = 5;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;

   localparam csr_index_type CSR_ROWS_IN_USE = 2'd0;
   localparam csr_index_type CSR_COLS_IN_USE = 2'd1;

   localparam csr_data_type ROWS_RESET = 5'd4;
   localparam csr_data_type COLS_RESET = 5'd5;

endpackage

/* rtl/core/max_sum_submatrix.sv */
// ----------------------------------------------------------------------------
// max_sum_submatrix
// loads a signed matrix row-major and returns the rectangle of greatest sum
// with its corner indices, using the two-dimensional Kadane search
// ----------------------------------------------------------------------------
// Elements are taken one per cycle and written to an on-chip store; the
// element marked last starts the search and the input stays not ready until
// it is over. The search walks every left/right column pair; for each pair a
// sequencer streams the rows through one shared three-stage datapath (store
// and column-sum reads, column-sum add, Kadane step), and once the datapath
// has drained the pair's result is compared with the best so far; the result
// is offered after the last pair.
// The result sits in an output register, so loading of the next matrix may
// go on while it waits to be taken. Register writes belong to idle periods.
// ----------------------------------------------------------------------------
module max_sum_submatrix #(
   parameter int MAX_ROWS     = 16,
   parameter int MAX_COLS     = 16,
   parameter int ELEMENT_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [ELEMENT_BITS-1:0]           req_element_value,
   input  logic                                     req_last_element,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [msm_pkg::BEST_SUM_BITS-1:0] rsp_best_sum,
   output logic [msm_pkg::INDEX_BITS-1:0]           rsp_top_row,
   output logic [msm_pkg::INDEX_BITS-1:0]           rsp_left_col,
   output logic [msm_pkg::INDEX_BITS-1:0]           rsp_bottom_row,
   output logic [msm_pkg::INDEX_BITS-1:0]           rsp_right_col,
   input  logic                                     csr_write_enable,
   input  msm_pkg::csr_index_type                   csr_index,
   input  msm_pkg::csr_data_type                    csr_write_data
);

   localparam int DEPTH        = MAX_ROWS * MAX_COLS;
   localparam int ADDR_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS     = $clog2(DEPTH + 1);
   localparam int ROW_BITS     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_BITS     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_CNT_BITS = $clog2(MAX_ROWS + 1);
   localparam int COL_CNT_BITS = $clog2(MAX_COLS + 1);
   localparam int SUM_BITS     = ELEMENT_BITS + ADDR_BITS + 1;
   localparam int SAT_BITS     = (SUM_BITS > msm_pkg::BEST_SUM_BITS) ?
                                 SUM_BITS : msm_pkg::BEST_SUM_BITS;
   localparam logic signed [SAT_BITS-1:0] SAT_HI =
      SAT_BITS'(2 ** (msm_pkg::BEST_SUM_BITS - 1) - 1);
   localparam logic signed [SAT_BITS-1:0] SAT_LO =
      SAT_BITS'(-(2 ** (msm_pkg::BEST_SUM_BITS - 1)));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type                   state_ff;
   msm_pkg::csr_data_type       rows_cfg_ff;
   msm_pkg::csr_data_type       cols_cfg_ff;
   logic [CNT_BITS-1:0]         load_count_ff;
   logic [COL_BITS-1:0]         left_ff;
   logic [COL_BITS-1:0]         right_ff;
   logic [ROW_BITS-1:0]         row_ff;
   logic [ADDR_BITS-1:0]        addr_ff;
   logic                        have_ff;
   logic signed [SUM_BITS-1:0]  best_ff;
   logic [ROW_BITS-1:0]         best_top_ff;
   logic [COL_BITS-1:0]         best_left_ff;
   logic [ROW_BITS-1:0]         best_bottom_ff;
   logic [COL_BITS-1:0]         best_right_ff;
   logic                        rsp_valid_ff;
   logic signed [msm_pkg::BEST_SUM_BITS-1:0] rsp_sum_ff;
   logic [msm_pkg::INDEX_BITS-1:0] rsp_top_ff;
   logic [msm_pkg::INDEX_BITS-1:0] rsp_left_ff;
   logic [msm_pkg::INDEX_BITS-1:0] rsp_bottom_ff;
   logic [msm_pkg::INDEX_BITS-1:0] rsp_right_ff;

   logic signed [ELEMENT_BITS-1:0] mat_mem [DEPTH];
   logic signed [SUM_BITS-1:0]     cs_mem  [MAX_ROWS];

   // datapath stages
   logic                        s1_vld_ff;
   logic [ROW_BITS-1:0]         s1_row_ff;
   logic                        s1_first_ff;
   logic signed [ELEMENT_BITS-1:0] mem_q_ff;
   logic signed [SUM_BITS-1:0]  cs_q_ff;
   logic                        s2_vld_ff;
   logic [ROW_BITS-1:0]         s2_row_ff;
   logic signed [SUM_BITS-1:0]  s2_sum_ff;
   logic signed [SUM_BITS-1:0]  run_ff;
   logic [ROW_BITS-1:0]         start_ff;
   logic                        found_ff;
   logic signed [SUM_BITS-1:0]  kbest_ff;
   logic [ROW_BITS-1:0]         ktop_ff;
   logic [ROW_BITS-1:0]         kbot_ff;
   logic signed [SUM_BITS-1:0]  fb_ff;
   logic [ROW_BITS-1:0]         fb_row_ff;

   logic [ROW_CNT_BITS-1:0]     rows_use;
   logic [COL_CNT_BITS-1:0]     cols_use;
   logic [CNT_BITS-1:0]         total;
   logic [ROW_BITS-1:0]         last_row;
   logic [COL_BITS-1:0]         last_col;
   logic                        req_xfer;
   logic                        store_en;
   logic                        issue;
   logic signed [SUM_BITS-1:0]  s2_sum_in;
   logic signed [SUM_BITS-1:0]  run_prev;
   logic                        found_prev;
   logic signed [SUM_BITS-1:0]  run_sum;
   logic signed [SUM_BITS-1:0]  pair_sum;
   logic [ROW_BITS-1:0]         pair_top;
   logic [ROW_BITS-1:0]         pair_bottom;
   logic signed [SAT_BITS-1:0]  best_wide;
   logic signed [msm_pkg::BEST_SUM_BITS-1:0] sat_sum;

   // clamped sizes
   always_comb begin
      if (rows_cfg_ff == '0) begin
         rows_use = ROW_CNT_BITS'(1);
      end else if (32'(rows_cfg_ff) > MAX_ROWS) begin
         rows_use = ROW_CNT_BITS'(MAX_ROWS);
      end else begin
         rows_use = ROW_CNT_BITS'(rows_cfg_ff);
      end
      if (cols_cfg_ff == '0) begin
         cols_use = COL_CNT_BITS'(1);
      end else if (32'(cols_cfg_ff) > MAX_COLS) begin
         cols_use = COL_CNT_BITS'(MAX_COLS);
      end else begin
         cols_use = COL_CNT_BITS'(cols_cfg_ff);
      end
   end

   assign total    = CNT_BITS'(32'(rows_use) * 32'(cols_use));
   assign last_row = ROW_BITS'(32'(rows_use) - 1);
   assign last_col = COL_BITS'(32'(cols_use) - 1);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign store_en  = req_xfer && (load_count_ff < total);
   assign issue     = (state_ff == ST_SCAN);

   // matrix store
   always_ff @(posedge clock) begin
      if (store_en) begin
         mat_mem[load_count_ff[ADDR_BITS-1:0]] <= req_element_value;
      end
      if (issue) begin
         mem_q_ff <= mat_mem[addr_ff];
      end
   end

   // column sums
   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         cs_mem[s1_row_ff] <= s2_sum_in;
      end
      if (issue) begin
         cs_q_ff <= cs_mem[row_ff];
      end
   end

   assign s2_sum_in = (s1_first_ff ? SUM_BITS'(0) : cs_q_ff) + SUM_BITS'(mem_q_ff);

   // kadane step, a new pair starts at row zero
   assign run_prev   = (s2_row_ff == '0) ? SUM_BITS'(0) : run_ff;
   assign found_prev = (s2_row_ff != '0) && found_ff;
   assign run_sum    = run_prev + s2_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
      s1_row_ff   <= row_ff;
      s1_first_ff <= (right_ff == left_ff);
      s2_row_ff   <= s1_row_ff;
      s2_sum_ff   <= s2_sum_in;
      if (s2_vld_ff) begin
         if (run_sum < 0) begin
            run_ff   <= '0;
            start_ff <= s2_row_ff + 1'b1;
            found_ff <= found_prev;
         end else begin
            run_ff <= run_sum;
            if (s2_row_ff == '0) begin
               start_ff <= '0;
            end
            if (!found_prev || run_sum > kbest_ff) begin
               kbest_ff <= run_sum;
               ktop_ff  <= (s2_row_ff == '0) ? '0 : start_ff;
               kbot_ff  <= s2_row_ff;
               found_ff <= 1'b1;
            end else begin
               found_ff <= found_prev;
            end
         end
         if (s2_row_ff == '0 || s2_sum_ff > fb_ff) begin
            fb_ff     <= s2_sum_ff;
            fb_row_ff <= s2_row_ff;
         end
      end
   end

   assign pair_sum    = found_ff ? kbest_ff : fb_ff;
   assign pair_top    = found_ff ? ktop_ff : fb_row_ff;
   assign pair_bottom = found_ff ? kbot_ff : fb_row_ff;

   assign best_wide = SAT_BITS'(best_ff);
   always_comb begin
      if (best_wide > SAT_HI) begin
         sat_sum = msm_pkg::BEST_SUM_BITS'(SAT_HI);
      end else if (best_wide < SAT_LO) begin
         sat_sum = msm_pkg::BEST_SUM_BITS'(SAT_LO);
      end else begin
         sat_sum = msm_pkg::BEST_SUM_BITS'(best_wide);
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rows_cfg_ff   <= msm_pkg::ROWS_RESET;
         cols_cfg_ff   <= msm_pkg::COLS_RESET;
         load_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               msm_pkg::CSR_ROWS_IN_USE: rows_cfg_ff <= csr_write_data;
               msm_pkg::CSR_COLS_IN_USE: cols_cfg_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (store_en) begin
                  load_count_ff <= load_count_ff + 1'b1;
               end
               if (req_xfer && req_last_element) begin
                  load_count_ff <= '0;
                  left_ff       <= '0;
                  right_ff      <= '0;
                  row_ff        <= '0;
                  addr_ff       <= '0;
                  have_ff       <= 1'b0;
                  state_ff      <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (row_ff == last_row) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  row_ff  <= row_ff + 1'b1;
                  addr_ff <= addr_ff + ADDR_BITS'(cols_use);
               end
            end
            ST_DRAIN: begin
               if (!s1_vld_ff && !s2_vld_ff) begin
                  if (!have_ff || pair_sum > best_ff) begin
                     best_ff        <= pair_sum;
                     best_top_ff    <= pair_top;
                     best_left_ff   <= left_ff;
                     best_bottom_ff <= pair_bottom;
                     best_right_ff  <= right_ff;
                  end
                  have_ff <= 1'b1;
                  row_ff  <= '0;
                  if (right_ff == last_col) begin
                     if (left_ff == last_col) begin
                        state_ff <= ST_DONE;
                     end else begin
                        left_ff  <= left_ff + 1'b1;
                        right_ff <= left_ff + 1'b1;
                        addr_ff  <= ADDR_BITS'(left_ff) + 1'b1;
                        state_ff <= ST_SCAN;
                     end
                  end else begin
                     right_ff <= right_ff + 1'b1;
                     addr_ff  <= ADDR_BITS'(right_ff) + 1'b1;
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_sum_ff    <= sat_sum;
                  rsp_top_ff    <= msm_pkg::INDEX_BITS'(best_top_ff);
                  rsp_left_ff   <= msm_pkg::INDEX_BITS'(best_left_ff);
                  rsp_bottom_ff <= msm_pkg::INDEX_BITS'(best_bottom_ff);
                  rsp_right_ff  <= msm_pkg::INDEX_BITS'(best_right_ff);
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_sum   = rsp_sum_ff;
   assign rsp_top_row    = rsp_top_ff;
   assign rsp_left_col   = rsp_left_ff;
   assign rsp_bottom_row = rsp_bottom_ff;
   assign rsp_right_col  = rsp_right_ff;

endmodule

/* rtl/core/msm_checker.sv */
// ----------------------------------------------------------------------------
// msm_checker
// port-level checks of the max-sum submatrix block, bound to its top level
// ----------------------------------------------------------------------------
module msm_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_valid,
   input logic                                     req_ready,
   input logic                                     req_last_element,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic signed [msm_pkg::BEST_SUM_BITS-1:0] rsp_best_sum,
   input logic [msm_pkg::INDEX_BITS-1:0]           rsp_top_row,
   input logic [msm_pkg::INDEX_BITS-1:0]           rsp_left_col,
   input logic [msm_pkg::INDEX_BITS-1:0]           rsp_bottom_row,
   input logic [msm_pkg::INDEX_BITS-1:0]           rsp_right_col
);

   // stalled result holds its sum, top row and right column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_sum)
         && $stable(rsp_top_row) && $stable(rsp_right_col))
      else $error("result changed while stalled");

   // rectangle corners are ordered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_top_row <= rsp_bottom_row && rsp_left_col <= rsp_right_col)
      else $error("result corners out of order");

   // last transfer starts a busy search
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_element |=> !req_ready)
      else $error("input ready right after last transfer");

   // no result straight out of reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind max_sum_submatrix msm_checker u_msm_checker (.*);
